// File: design/grcc_pkg.sv
package grcc_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_CLOSE,
        ST_COUNT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_row;
        logic init;
        logic close_step;
        logic count_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_last;
    } stat_t;

    localparam int COUNT_W = 6;
    localparam int ROW_IN_W = 32;

endpackage

// File: design/grcc_ctrl.sv
module grcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_row,
    input  grcc_pkg::stat_t   stat,
    output grcc_pkg::cmd_t    cmd,
    output logic              busy
);

    grcc_pkg::state_t state_reg;
    grcc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grcc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            grcc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_row = 1'b1;
                    if (last_row)
                    begin
                        state_next = grcc_pkg::ST_INIT;
                    end
                end
            end
            grcc_pkg::ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = grcc_pkg::ST_CLOSE;
            end
            grcc_pkg::ST_CLOSE:
            begin
                cmd.close_step = 1'b1;
                if (stat.step_last)
                begin
                    state_next = grcc_pkg::ST_COUNT;
                end
            end
            grcc_pkg::ST_COUNT:
            begin
                // The datapath registers the result on the last scan step.
                cmd.count_step = 1'b1;
                if (stat.step_last)
                begin
                    state_next = grcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = grcc_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == grcc_pkg::ST_INIT) |=> (state_reg == grcc_pkg::ST_CLOSE))
        else $error("closure did not follow the init step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_row) |=> !busy)
        else $error("a plain row load left the block busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == grcc_pkg::ST_COUNT && !stat.step_last)
            |=> (state_reg == grcc_pkg::ST_COUNT))
        else $error("origin scan ended early");

endmodule

// File: design/grcc_dp.sv
module grcc_dp #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  grcc_pkg::cmd_t                      cmd,
    output grcc_pkg::stat_t                     stat,
    input  logic [grcc_pkg::ROW_IN_W-1:0]       row_mask,
    input  logic                                cfg_we,
    input  logic [grcc_pkg::COUNT_W-1:0]        cfg_wdata,
    output logic [grcc_pkg::COUNT_W-1:0]        origin_count,
    output logic                                connected,
    output logic                                done
);

    localparam int N_W   = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [grcc_pkg::COUNT_W-1:0] vcount_reg;
    logic [N_W-1:0]               n_cur;
    logic [MAX_VERTICES-1:0]      full;
    logic [MAX_VERTICES-1:0]      row_in;

    logic [MAX_VERTICES-1:0]      adj_reg    [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]      reach_reg  [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]      reach_next [MAX_VERTICES];

    logic [N_W-1:0]               row_cnt_reg;
    logic [IDX_W-1:0]             step_reg;
    logic [IDX_W-1:0]             step_next;
    logic [N_W-1:0]               cnt_reg;
    logic [N_W-1:0]               cnt_next;
    logic [MAX_VERTICES-1:0]      visited_reg;
    logic [MAX_VERTICES-1:0]      visited_next;
    logic [MAX_VERTICES-1:0]      spread;

    logic [MAX_VERTICES-1:0]      pivot;
    logic                         hit;
    logic                         step_last;
    logic                         row_fits;
    logic                         done_reg;
    logic [grcc_pkg::COUNT_W-1:0] origin_count_reg;
    logic                         connected_reg;

    // Out-of-range counts: zero acts as one, large values saturate.
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_cur = N_W'(1);
        end
        else if (int'(vcount_reg) > MAX_VERTICES)
        begin
            n_cur = N_W'(MAX_VERTICES);
        end
        else
        begin
            n_cur = N_W'(vcount_reg);
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            full[j] = (j < int'(n_cur));
        end
    end

    assign row_in    = MAX_VERTICES'(row_mask);
    assign row_fits  = (row_cnt_reg < n_cur);
    assign pivot     = reach_reg[step_reg];
    assign hit       = &(pivot | ~full);
    assign step_last = (N_W'(step_reg) == (n_cur - N_W'(1)));
    assign stat.step_last = step_last;

    // One Warshall pivot per cycle: every row that reaches the pivot takes
    // over the pivot's row. The pivot row itself cannot change in its step.
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            if (cmd.init)
            begin
                reach_next[i] = (adj_reg[i] & full) | (MAX_VERTICES'(1) << i);
            end
            else if (cmd.close_step && reach_reg[i][step_reg])
            begin
                reach_next[i] = reach_reg[i] | pivot;
            end
            else
            begin
                reach_next[i] = reach_reg[i];
            end
        end
    end

    // Undirected frontier expansion: j joins if it has an edge to or from a
    // visited vertex. Visited only holds bits below n, so rows above n drop out.
    always_comb
    begin
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            spread[j] = |(adj_reg[j] & visited_reg);
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                spread[j] = spread[j] | (visited_reg[i] & adj_reg[i][j]);
            end
        end
    end

    always_comb
    begin
        visited_next = visited_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        if (cmd.init)
        begin
            visited_next = MAX_VERTICES'(1);
            step_next    = '0;
            cnt_next     = '0;
        end
        else if (cmd.close_step)
        begin
            visited_next = full & (visited_reg | spread);
            step_next    = step_last ? '0 : step_reg + IDX_W'(1);
        end
        else if (cmd.count_step)
        begin
            cnt_next  = cnt_reg + N_W'(hit);
            step_next = step_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row && row_fits)
        begin
            adj_reg[row_cnt_reg[IDX_W-1:0]] <= row_in & full;
        end
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            reach_reg[i] <= reach_next[i];
        end
        if (cmd.count_step && step_last)
        begin
            origin_count_reg <= grcc_pkg::COUNT_W'(cnt_next);
            connected_reg    <= ((visited_reg & full) == full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg  <= grcc_pkg::COUNT_W'(32);
            row_cnt_reg <= '0;
            step_reg    <= '0;
            cnt_reg     <= '0;
            visited_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (cmd.init)
            begin
                row_cnt_reg <= '0;
            end
            else if (cmd.load_row && row_fits)
            begin
                row_cnt_reg <= row_cnt_reg + N_W'(1);
            end
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            visited_reg <= visited_next;
            done_reg    <= cmd.count_step && step_last;
        end
    end

    assign origin_count = origin_count_reg;
    assign connected    = connected_reg;
    assign done         = done_reg;

endmodule

// File: design/graph_root_count_and_connectivity_core.sv
// Row loads: a transaction without last_row leaves the block idle; busy stays low.
// Last row: busy through one init step, n closure pivots and n origin-scan steps,
// n = vertex_count clamped to 1..MAX_VERTICES; done pulses off the last scan step.
// Computing a graph is paced by the one-pivot-per-cycle closure and the
// one-row-per-cycle origin scan. The receiver cannot stall done.
// Reset is asynchronous and active low: idle, row counter zero, vertex_count 32.
module graph_root_count_and_connectivity_core #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [grcc_pkg::ROW_IN_W-1:0]       row_mask,
    input  logic                                last_row,
    input  logic                                cfg_we,
    input  logic [grcc_pkg::COUNT_W-1:0]        cfg_wdata,
    output logic                                done,
    output logic [grcc_pkg::COUNT_W-1:0]        origin_count,
    output logic                                connected
);

    grcc_pkg::cmd_t  cmd;
    grcc_pkg::stat_t stat;

    grcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_row (last_row),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    grcc_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .row_mask     (row_mask),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .origin_count (origin_count),
        .connected    (connected),
        .done         (done)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while the block is still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding computation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_row) |=> busy)
        else $error("last row did not start the computation");

endmodule

// File: tb/sv/tb_graph_root_count_and_connectivity_core.sv
module tb_graph_root_count_and_connectivity_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_V = 32;
    localparam int RANDOM_ITEMS = 600;
    localparam int CFG_GUARD = 4;
    localparam int DRAIN_CYCLES = 2 * MAX_V + 8;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_SPARSE,
        SHAPE_RING,
        SHAPE_HUB,
        SHAPE_DENSE,
        SHAPE_EMPTY
    } row_shape_t;

    typedef enum int {
        LOAD_EXACT,
        LOAD_EXTRA_ROWS,
        LOAD_SHORT,
        LOAD_RESIZE_MIDWAY
    } load_kind_t;

    typedef struct packed {
        logic [grcc_pkg::COUNT_W-1:0] origin_count;
        logic                         connected;
    } graph_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [grcc_pkg::ROW_IN_W-1:0] row_mask;
    logic                          last_row;
    logic                          cfg_we;
    logic [grcc_pkg::COUNT_W-1:0]  cfg_wdata;
    logic                          done;
    logic [grcc_pkg::COUNT_W-1:0]  origin_count;
    logic                          connected;

    // Shadow copy of the block's graph storage and register.
    logic [31:0]   adj_rows [MAX_V];
    int            next_row;
    logic [5:0]    vertex_count_reg;

    graph_result_t pending_graph_results[$];
    graph_result_t oldest_result;
    int            error_count = 0;
    int            rows_sent = 0;
    int            burst_left = 0;

    graph_root_count_and_connectivity_core #(
        .MAX_VERTICES(MAX_V)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .row_mask    (row_mask),
        .last_row    (last_row),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .origin_count(origin_count),
        .connected   (connected)
    );

    always #1 clk = ~clk;

    function automatic int active_vertices(input logic [5:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_V)
            return MAX_V;
        return int'(raw);
    endfunction

    function automatic logic [31:0] vertex_mask(input int n);
        return 32'((64'd1 << n) - 64'd1);
    endfunction

    function automatic graph_result_t predict_graph_result(input int n);
        logic [31:0]   full;
        logic [31:0]   reach [MAX_V];
        logic [31:0]   seen;
        logic [31:0]   prev;
        int            roots;
        graph_result_t res;
        full = vertex_mask(n);
        roots = 0;
        for (int i = 0; i < n; i++)
            reach[i] = (adj_rows[i] & full) | (32'h1 << i);
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                if (reach[i][k])
                    reach[i] |= reach[k];
        for (int i = 0; i < n; i++)
            if ((reach[i] & full) == full)
                roots++;
        // Weak connectivity: flood from vertex 0 over edges in both directions.
        seen = 32'h1;
        do
        begin
            prev = seen;
            for (int i = 0; i < n; i++)
            begin
                if (seen[i])
                begin
                    seen |= adj_rows[i] & full;
                    for (int j = 0; j < n; j++)
                        if (adj_rows[j][i])
                            seen[j] = 1'b1;
                end
            end
        end
        while (seen != prev);
        res.origin_count = grcc_pkg::COUNT_W'(roots);
        res.connected = ((seen & full) == full);
        return res;
    endfunction

    function automatic void load_row_model(input logic [31:0] mask, input logic last);
        int n;
        n = active_vertices(vertex_count_reg);
        if (next_row < n)
        begin
            adj_rows[next_row] = mask & vertex_mask(n);
            next_row++;
        end
        if (last)
        begin
            pending_graph_results.push_back(predict_graph_result(n));
            next_row = 0;
        end
    endfunction

    function automatic logic [31:0] make_row(input row_shape_t shape, input int i,
                                             input int n, input int hub);
        logic [31:0] full;
        logic [31:0] r;
        full = vertex_mask(n);
        case (shape)
            SHAPE_RANDOM: r = $urandom();
            SHAPE_SPARSE:
            begin
                r = 32'h1 << $urandom_range(0, n - 1);
                if ($urandom_range(0, 1) == 0)
                    r |= 32'h1 << $urandom_range(0, n - 1);
            end
            SHAPE_RING:
            begin
                r = 32'h1 << ((i + 1) % n);
                if ($urandom_range(0, 7) == 0)
                    r |= $urandom() & $urandom();
            end
            SHAPE_HUB:
            begin
                if (i == hub)
                    r = full;
                else if ($urandom_range(0, 3) == 0)
                    r = 32'h1 << $urandom_range(0, n - 1);
                else
                    r = '0;
            end
            SHAPE_DENSE: r = $urandom() | $urandom() | $urandom();
            default: r = '0;
        endcase
        // Junk above the active vertex range must be ignored by the block.
        if ($urandom_range(0, 3) == 0)
            r |= $urandom() & ~full;
        return r;
    endfunction

    function automatic logic [5:0] pick_vertex_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 6'($urandom_range(1, 6));
        if (r < 16)
            return 6'($urandom_range(7, 31));
        if (r < 18)
            return 6'(MAX_V);
        if (r == 18)
            return 6'd0;
        return 6'($urandom_range(33, 63));
    endfunction

    // The caller must drive the next transaction or call hold_off at the next falling edge.
    task automatic send_row(input logic [31:0] mask, input logic last);
        @(negedge clk);
        start <= 1'b1;
        row_mask <= mask;
        last_row <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        load_row_model(mask, last);
        rows_sent++;
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_row_bursty(input logic [31:0] mask, input logic last);
        send_row(mask, last);
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 15));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic write_vertex_count(input logic [5:0] value);
        hold_off(1);
        while (pending_graph_results.size() != 0)
            @(posedge clk);
        repeat (CFG_GUARD)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        vertex_count_reg = value;
    endtask

    // Fills every row at the reset vertex count so later short loads read known rows.
    task automatic test_ring_full_load();
        for (int i = 0; i < MAX_V; i++)
            send_row(32'h1 << ((i + 1) % MAX_V), i == MAX_V - 1);
    endtask

    task automatic test_single_vertex();
        write_vertex_count(6'd1);
        send_row(32'hFFFF_FFFF, 1'b1);
        write_vertex_count(6'd0);
        send_row(32'h0000_0000, 1'b1);
    endtask

    task automatic test_saturated_short_load();
        write_vertex_count(6'd63);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h0000_0000, 1'b1);
    endtask

    task automatic test_extra_rows_and_bits();
        write_vertex_count(6'd3);
        send_row(32'hFFFF_FFFA, 1'b0);
        send_row(32'h8000_0004, 1'b0);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h0000_0007, 1'b1);
    endtask

    task automatic test_resize_mid_load();
        write_vertex_count(6'd5);
        send_row(32'h0000_0002, 1'b0);
        send_row(32'h0000_0001, 1'b0);
        send_row(32'h0000_0010, 1'b0);
        write_vertex_count(6'd2);
        send_row(32'h0000_0003, 1'b1);
    endtask

    task automatic test_two_components();
        write_vertex_count(6'd4);
        send_row(32'h0000_0002, 1'b0);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'h0000_0008, 1'b0);
        send_row(32'h0000_0004, 1'b1);
    endtask

    task automatic test_random_graphs();
        int         target;
        int         n;
        int         rows;
        int         hub;
        row_shape_t shape;
        load_kind_t kind;
        target = rows_sent + RANDOM_ITEMS;
        burst_left = $urandom_range(1, 24);
        while (rows_sent < target)
        begin
            if ($urandom_range(0, 3) == 0)
                write_vertex_count(pick_vertex_count());
            n = active_vertices(vertex_count_reg);
            shape = row_shape_t'($urandom_range(0, 5));
            hub = $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
                7: kind = LOAD_EXTRA_ROWS;
                8: kind = LOAD_SHORT;
                9: kind = LOAD_RESIZE_MIDWAY;
                default: kind = LOAD_EXACT;
            endcase
            case (kind)
                LOAD_EXTRA_ROWS: rows = n + $urandom_range(1, 3);
                LOAD_SHORT: rows = $urandom_range(1, n);
                LOAD_RESIZE_MIDWAY: rows = $urandom_range(1, n);
                default: rows = n;
            endcase
            for (int k = 0; k < rows; k++)
                send_row_bursty(make_row(shape, k, n, hub),
                                kind != LOAD_RESIZE_MIDWAY && k == rows - 1);
            if (kind == LOAD_RESIZE_MIDWAY)
            begin
                write_vertex_count(pick_vertex_count());
                n = active_vertices(vertex_count_reg);
                rows = $urandom_range(1, n);
                for (int k = 0; k < rows; k++)
                    send_row_bursty(make_row(shape, k, n, hub), k == rows - 1);
            end
        end
    endtask

    task automatic drain_results();
        hold_off(1);
        while (pending_graph_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_graph_results.size() == 0)
            begin
                $error("unexpected result: origin_count %0d, connected %0d",
                       origin_count, connected);
                error_count++;
            end
            else
            begin
                oldest_result = pending_graph_results.pop_front();
                if (origin_count !== oldest_result.origin_count)
                begin
                    $error("origin_count mismatch: expected %0d, actual %0d",
                           oldest_result.origin_count, origin_count);
                    error_count++;
                end
                if (connected !== oldest_result.connected)
                begin
                    $error("connected mismatch: expected %0d, actual %0d",
                           oldest_result.connected, connected);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("graph_root_count_and_connectivity_core test failed");
        $finish;
    end

    initial
    begin
        start = 1'b0;
        row_mask = '0;
        last_row = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        for (int i = 0; i < MAX_V; i++)
            adj_rows[i] = '0;
        next_row = 0;
        vertex_count_reg = 6'(MAX_V);
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ring_full_load();
        test_single_vertex();
        test_saturated_short_load();
        test_extra_rows_and_bits();
        test_resize_mid_load();
        test_two_components();
        test_random_graphs();
        drain_results();

        if (error_count == 0)
            $display("graph_root_count_and_connectivity_core test passed");
        else
            $display("graph_root_count_and_connectivity_core test failed");
        $finish;
    end

endmodule
